// ===== src/impt_pkg.sv =====
package impt_pkg;

    localparam int DATA_W    = 32;
    localparam int DIM_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'b1;

    typedef logic [DATA_W-1:0] element_t;
    typedef logic [DIM_W-1:0]  dim_t;

endpackage

// ===== src/in_place_matrix_transpose.sv =====
// In-place matrix transpose by cycle following.
// Set the matrix shape first on the configuration channel: index 0 is the row
// count and index 1 the column count, both 1 to 64 with a product that fits the
// store. The configuration channel is always ready.
// Elements enter row-major on the s_axis channel, one per cycle while the block
// is idle. Elements beyond the store capacity are dropped. The transaction with
// tlast set ends the matrix and starts the transpose; tready stays low until the
// whole transposed matrix has been delivered.
// Each moved element takes one multiply, a pass through the shared remainder unit,
// which yields an IW-bit index (IW is the index width, 6 for a 64-entry store) and
// whose last step issues the store read, and a store write. Starting each new cycle
// adds a read and a scan of the visited bits, one index per cycle.
// The transposed matrix then leaves row-major on m_axis, each element read from the
// store, loaded into the output register and held until taken, with tlast on the
// final element; the next element is read only after the last one is taken. When the receiver stalls, the block waits.
// Bad dimensions produce no output. Reset returns the shape to 1 x 1 and empties
// the load count; the store contents are undefined until written.
module in_place_matrix_transpose
    import impt_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [DATA_W-1:0]    s_axis_tdata,   // element_value[31:0]
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [DATA_W-1:0]    m_axis_tdata,   // out_value[31:0]
    output logic                 m_axis_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    localparam int IW  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int LCW = $clog2(MAX_ELEMENTS + 1);
    localparam int PW  = IW + DIM_W;
    localparam int TW  = 2 * DIM_W;
    localparam logic [TW-1:0]  MAX_TOTAL = TW'(MAX_ELEMENTS);
    localparam logic [LCW-1:0] MAX_LOAD  = LCW'(MAX_ELEMENTS);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SIZE     = 4'd1;
    localparam logic [3:0] S_CHECK    = 4'd2;
    localparam logic [3:0] S_CYC_RD   = 4'd3;
    localparam logic [3:0] S_CYC_LD   = 4'd4;
    localparam logic [3:0] S_MUL      = 4'd5;
    localparam logic [3:0] S_MOD      = 4'd6;
    localparam logic [3:0] S_MOVE_WR  = 4'd7;
    localparam logic [3:0] S_SCAN     = 4'd8;
    localparam logic [3:0] S_OUT_RD   = 4'd9;
    localparam logic [3:0] S_OUT_LD   = 4'd10;
    localparam logic [3:0] S_OUT_HOLD = 4'd11;

    logic [3:0]            state_reg;
    logic [3:0]            state_next;
    dim_t                  row_count_reg;
    dim_t                  row_count_next;
    dim_t                  column_count_reg;
    dim_t                  column_count_next;
    logic [LCW-1:0]        load_count_reg;
    logic [LCW-1:0]        load_count_next;
    logic [TW-1:0]         total_reg;
    logic [TW-1:0]         total_next;
    logic [IW-1:0]         last_index_reg;
    logic [IW-1:0]         last_index_next;
    logic [MAX_ELEMENTS-1:0] visited_reg;
    logic [MAX_ELEMENTS-1:0] visited_next;
    logic [IW-1:0]         start_reg;
    logic [IW-1:0]         start_next;
    logic [IW-1:0]         idx_reg;
    logic [IW-1:0]         idx_next;
    logic [IW-1:0]         dest_reg;
    logic [IW-1:0]         dest_next;
    logic [IW-1:0]         scan_reg;
    logic [IW-1:0]         scan_next;
    logic [IW-1:0]         out_idx_reg;
    logic [IW-1:0]         out_idx_next;
    element_t              carried_reg;
    element_t              carried_next;
    element_t              out_data_reg;
    element_t              out_data_next;
    logic                  out_last_reg;
    logic                  out_last_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    logic                  in_fire;
    logic                  ram_wr_en;
    logic [IW-1:0]         ram_wr_addr;
    element_t              ram_wr_data;
    logic [IW-1:0]         ram_rd_addr;
    element_t              ram_rd_data;
    logic                  mod_start;
    logic [PW-1:0]         mod_dividend;
    logic                  mod_done;
    logic [IW-1:0]         mod_rem;
    logic [IW-1:0]         check_last;

    impt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    impt_modulo #(
        .IW (IW)
    ) u_modulo (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (last_index_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign mod_dividend  = PW'(idx_reg) * PW'(row_count_reg);
    assign mod_start     = (state_reg == S_MUL);
    assign check_last    = IW'(total_reg - 1'b1);

    always_comb
    begin
        row_count_next    = row_count_reg;
        column_count_next = column_count_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ROW_COUNT:    row_count_next    = cfg_data;
                CFG_COLUMN_COUNT: column_count_next = cfg_data;
                default:          row_count_next    = row_count_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        total_next      = total_reg;
        last_index_next = last_index_reg;
        visited_next    = visited_reg;
        start_next      = start_reg;
        idx_next        = idx_reg;
        dest_next       = dest_reg;
        scan_next       = scan_reg;
        out_idx_next    = out_idx_reg;
        carried_next    = carried_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = load_count_reg[IW-1:0];
        ram_wr_data     = s_axis_tdata;
        ram_rd_addr     = start_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (load_count_reg < MAX_LOAD)
                    begin
                        ram_wr_en       = 1'b1;
                        load_count_next = load_count_reg + 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        load_count_next = '0;
                        state_next      = S_SIZE;
                    end
                end
            end
            S_SIZE:
            begin
                total_next = TW'(row_count_reg) * TW'(column_count_reg);
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if ((row_count_reg == '0) || (column_count_reg == '0)
                    || (total_reg > MAX_TOTAL))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    last_index_next = check_last;
                    out_idx_next    = '0;
                    visited_next    = '0;
                    if (total_reg < TW'(3))
                    begin
                        state_next = S_OUT_RD;
                    end
                    else
                    begin
                        visited_next[0]          = 1'b1;
                        visited_next[check_last] = 1'b1;
                        start_next               = IW'(1);
                        state_next               = S_CYC_RD;
                    end
                end
            end
            S_CYC_RD:
            begin
                ram_rd_addr = start_reg;
                idx_next    = start_reg;
                state_next  = S_CYC_LD;
            end
            S_CYC_LD:
            begin
                carried_next = ram_rd_data;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_MOD;
            end
            S_MOD:
            begin
                ram_rd_addr = mod_rem;
                if (mod_done)
                begin
                    dest_next  = mod_rem;
                    state_next = S_MOVE_WR;
                end
            end
            S_MOVE_WR:
            begin
                ram_wr_en             = 1'b1;
                ram_wr_addr           = dest_reg;
                ram_wr_data           = carried_reg;
                carried_next          = ram_rd_data;
                visited_next[idx_reg] = 1'b1;
                idx_next              = dest_reg;
                if (dest_reg == start_reg)
                begin
                    scan_next  = start_reg + 1'b1;
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_SCAN:
            begin
                if (scan_reg >= last_index_reg)
                begin
                    state_next = S_OUT_RD;
                end
                else if (!visited_reg[scan_reg])
                begin
                    start_next = scan_reg;
                    state_next = S_CYC_RD;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_OUT_RD:
            begin
                ram_rd_addr = out_idx_reg;
                state_next  = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                out_data_next  = ram_rd_data;
                out_last_next  = (out_idx_reg == last_index_reg);
                out_valid_next = 1'b1;
                state_next     = S_OUT_HOLD;
            end
            S_OUT_HOLD:
            begin
                if (m_axis_tready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 1'b1;
                        state_next   = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            row_count_reg    <= DIM_W'(1);
            column_count_reg <= DIM_W'(1);
            load_count_reg   <= '0;
            visited_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            row_count_reg    <= row_count_next;
            column_count_reg <= column_count_next;
            load_count_reg   <= load_count_next;
            visited_reg      <= visited_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg      <= total_next;
        last_index_reg <= last_index_next;
        start_reg      <= start_next;
        idx_reg        <= idx_next;
        dest_reg       <= dest_next;
        scan_reg       <= scan_next;
        out_idx_reg    <= out_idx_next;
        carried_reg    <= carried_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
    end

endmodule

// ===== src/impt_ram.sv =====
module impt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                         clk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/impt_modulo.sv =====
module impt_modulo
    import impt_pkg::*;
#(
    parameter int IW = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [IW+DIM_W-1:0]   dividend,
    input  logic [IW-1:0]         divisor,
    output logic                  done,
    output logic [IW-1:0]         remainder
);

    // Restoring remainder, one dividend bit per cycle.
    localparam int PW = IW + DIM_W;
    localparam int CW = $clog2(PW + 1);

    logic [PW-1:0] dvd_reg;
    logic [PW-1:0] dvd_next;
    logic [IW-1:0] rem_reg;
    logic [IW-1:0] rem_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [IW:0]   shifted;

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, dvd_reg[PW-1]};
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            cnt_next  = CW'(PW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, divisor})
            begin
                rem_next = IW'(shifted - {1'b0, divisor});
            end
            else
            begin
                rem_next = shifted[IW-1:0];
            end
            dvd_next = {dvd_reg[PW-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== dv/tb_in_place_matrix_transpose.sv =====
module tb_in_place_matrix_transpose;
    import impt_pkg::*;

    localparam int STORE_DEPTH   = 64;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 100;
    localparam int STALL_LIMIT   = 20000;
    localparam int RANDOM_ITEMS  = 75;
    localparam int HOLD_MATRIX   = 4;
    localparam int NUM_DIRECTED  = 11;

    typedef struct packed {
        element_t value;
        logic     last;
    } out_beat_t;

    typedef struct packed {
        dim_t       rows;
        dim_t       cols;
        logic [7:0] count;
        element_t   base;
        element_t   stride;
        logic       typed;
        logic       typed_count;
        element_t   typed_value;
    } directed_row_t;

    // Rows marked typed carry their own expectation; the rest go through the shadow model.
    localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{7'd1,   7'd1, 8'd1, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{7'd1,   7'd1, 8'd1, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
        '{7'd1,   7'd2, 8'd2, 32'h8000_0000, 32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000},
        '{7'd2,   7'd1, 8'd2, 32'h0000_0001, 32'h8000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{7'd2,   7'd3, 8'd6, 32'h0000_0010, 32'h1111_1111, 1'b0, 1'b0, 32'h0000_0000},
        '{7'd3,   7'd2, 8'd4, 32'hA5A5_0000, 32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000},
        '{7'd2,   7'd2, 8'd4, 32'h5A5A_5A5A, 32'h0101_0101, 1'b0, 1'b0, 32'h0000_0000},
        '{7'd0,   7'd3, 8'd2, 32'hDEAD_0000, 32'h0000_0001, 1'b1, 1'b0, 32'h0000_0000},
        '{7'd5,   7'd0, 8'd1, 32'h1234_5678, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{7'd127, 7'd1, 8'd1, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{7'd64,  7'd2, 8'd1, 32'hC3C3_C3C3, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000}
    };

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [DATA_W-1:0]    s_axis_tdata  = '0;    // element_value[31:0]
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [DATA_W-1:0]    m_axis_tdata;          // out_value[31:0]
    logic                 m_axis_tlast;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = CFG_ROW_COUNT;
    logic [DIM_W-1:0]     cfg_data      = '0;

    dim_t      shape_rows = 7'd1;
    dim_t      shape_cols = 7'd1;
    element_t  shadow_store [STORE_DEPTH];
    bit        written      [STORE_DEPTH];
    bit [STORE_DEPTH-1:0] visited;
    int        fill_count = 0;

    out_beat_t expected_beats [$];
    out_beat_t want;
    int        mismatch_count = 0;
    int        items_sent     = 0;
    int        burst_left     = 0;
    int        quiet_cycles   = 0;
    bit        typed_on       = 1'b0;
    bit        typed_count    = 1'b0;
    element_t  typed_value    = '0;
    bit        hold_request   = 1'b0;

    in_place_matrix_transpose #(
        .MAX_ELEMENTS (STORE_DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void transpose_shadow(input int rows, input int total);
        int       last_index;
        int       start;
        int       idx;
        int       dest;
        element_t carried;
        element_t held;
        visited = '0;
        if (total < 3)
        begin
            return;
        end
        last_index          = total - 1;
        visited[0]          = 1'b1;
        visited[last_index] = 1'b1;
        start               = 1;
        while (start < last_index)
        begin
            idx     = start;
            carried = shadow_store[idx];
            do
            begin
                dest               = (idx * rows) % last_index;
                held               = shadow_store[dest];
                shadow_store[dest] = carried;
                carried            = held;
                visited[idx]       = 1'b1;
                idx                = dest;
            end while (idx != start);
            start = 1;
            while (start < last_index && visited[start])
            begin
                start++;
            end
        end
    endfunction

    function automatic void load_shadow(input element_t value, input logic last);
        int total;
        if (fill_count < STORE_DEPTH)
        begin
            shadow_store[fill_count] = value;
            written[fill_count]      = 1'b1;
            fill_count++;
        end
        if (last)
        begin
            fill_count = 0;
            total      = int'(shape_rows) * int'(shape_cols);
            if (shape_rows != 0 && shape_cols != 0 && total <= STORE_DEPTH)
            begin
                transpose_shadow(int'(shape_rows), total);
                if (!typed_on)
                begin
                    for (int k = 0; k < total; k++)
                    begin
                        expected_beats.push_back('{shadow_store[k], k == total - 1});
                    end
                end
            end
            if (typed_on && typed_count)
            begin
                expected_beats.push_back('{typed_value, 1'b1});
            end
        end
    endfunction

    task automatic send_element(input element_t value, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        burst_left--;
        items_sent++;
        load_shadow(value, last);
        @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input dim_t value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (index == CFG_ROW_COUNT)
        begin
            shape_rows = value;
        end
        else
        begin
            shape_cols = value;
        end
        @(negedge clk);
    endtask

    task automatic set_shape(input dim_t rows, input dim_t cols);
        write_register(CFG_ROW_COUNT, rows);
        write_register(CFG_COLUMN_COUNT, cols);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_beats.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Receiver: segments of always-ready, random and patterned stalls, plus one long hold-off.
    initial
    begin
        int   stall_left;
        int   stall_mode;
        logic ready_next;
        stall_left = 0;
        stall_mode = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                if (stall_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    stall_left = $urandom_range(10, 60);
                end
                stall_left--;
                case (stall_mode)
                    0:       ready_next = 1'b1;
                    1:       ready_next = 1'($urandom_range(0, 1));
                    2:       ready_next = (stall_left % 3 == 0);
                    default: ready_next = ($urandom_range(0, 3) == 0);
                endcase
                m_axis_tready <= ready_next;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_beats.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("unexpected output transaction: data %h last %b",
                             m_axis_tdata, m_axis_tlast);
                end
            end
            else
            begin
                want = expected_beats.pop_front();
                if (want.value !== m_axis_tdata || want.last !== m_axis_tlast)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("output mismatch: expected data %h last %b,",
                                 want.value, want.last,
                                 " got data %h last %b", m_axis_tdata, m_axis_tlast);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb_in_place_matrix_transpose: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        directed_row_t row;
        int            rows;
        int            cols;
        int            total;
        int            count;
        int            pick;
        int            matrix;
        int            random_start;
        bit            reshape;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            shadow_store[i] = '0;
            written[i]      = 1'b0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            row = DIRECTED_ROWS[i];
            wait_drain();
            set_shape(row.rows, row.cols);
            typed_on    = row.typed;
            typed_count = row.typed_count;
            typed_value = row.typed_value;
            for (int k = 0; k < int'(row.count); k++)
            begin
                send_element(row.base + element_t'(k) * row.stride,
                             k == int'(row.count) - 1);
            end
            typed_on = 1'b0;
        end

        rows         = 1;
        cols         = 1;
        matrix       = 0;
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS || matrix <= HOLD_MATRIX)
        begin
            reshape = (matrix < 3) || (matrix != HOLD_MATRIX && $urandom_range(0, 2) != 0);
            if (matrix == 0)
            begin
                rows = 8;
                cols = 8;
            end
            else if (matrix == 1)
            begin
                rows = 64;
                cols = 1;
            end
            else if (matrix == 2)
            begin
                rows = 1;
                cols = 64;
            end
            else if (reshape)
            begin
                pick = (matrix == HOLD_MATRIX - 1) ? 2 : $urandom_range(0, 15);
                if (pick == 0)
                begin
                    rows = $urandom_range(1, 64);
                    cols = $urandom_range(1, 64 / rows);
                end
                else if (pick == 1)
                begin
                    rows = $urandom_range(0, 127);
                    cols = (rows == 0) ? $urandom_range(0, 127)
                                       : $urandom_range(64 / rows + 1, 127);
                end
                else
                begin
                    rows = $urandom_range(1, 6);
                    cols = $urandom_range(1, 6);
                end
            end
            if (reshape)
            begin
                wait_drain();
                set_shape(dim_t'(rows), dim_t'(cols));
            end
            if (matrix == HOLD_MATRIX)
            begin
                hold_request = 1'b1;
            end

            total = rows * cols;
            if (rows == 0 || cols == 0 || total > STORE_DEPTH)
            begin
                count = $urandom_range(1, 4);
            end
            else
            begin
                pick = $urandom_range(0, 9);
                if (matrix == 0)
                begin
                    count = total + $urandom_range(1, 4);
                end
                else if (matrix < 3)
                begin
                    count = $urandom_range(1, 4);
                end
                else if (pick < 7)
                begin
                    count = total;
                end
                else if (pick < 9)
                begin
                    count = $urandom_range(1, total);
                end
                else
                begin
                    count = total + $urandom_range(1, 3);
                end
                // A short load must not leave a never-written entry inside the matrix.
                for (int k = 0; k < total; k++)
                begin
                    if (!written[k] && count < k + 1)
                    begin
                        count = k + 1;
                    end
                end
            end
            for (int k = 0; k < count; k++)
            begin
                send_element(element_t'($urandom()), k == count - 1);
            end
            matrix++;
        end

        wait_drain();
        if (mismatch_count == 0 && expected_beats.size() == 0)
        begin
            $display("tb_in_place_matrix_transpose: PASS");
        end
        else
        begin
            $display("tb_in_place_matrix_transpose: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/impt_pkg.sv
src/impt_ram.sv
src/impt_modulo.sv
src/in_place_matrix_transpose.sv
dv/tb_in_place_matrix_transpose.sv
